[rtl/core/sitda_pkg.sv]
// Package for the signed integer to decimal ASCII converter.
// Holds shared widths, character codes, the sequencer state type and the control struct.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sitda_pkg;

    localparam int VALUE_W     = 32;
    localparam int CHAR_W      = 8;
    localparam int DIGIT_W     = 4;
    localparam int NUM_DIGITS  = 10;
    localparam int DIGIT_IDX_W = $clog2(NUM_DIGITS);
    localparam int CNT_W       = $clog2(VALUE_W);
    localparam int BCD_W       = NUM_DIGITS * DIGIT_W;

    localparam logic [CHAR_W-1:0] CODE_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] CODE_MINUS = 8'd45;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_SIGN,
        ST_SKIP,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic shift;
    } dab_ctrl_t;

endpackage

`default_nettype wire

[rtl/core/sitda_if.sv]
// Channel interfaces for the signed integer to decimal ASCII converter.
// Depends on sitda_pkg for payload widths.
`timescale 1ns / 1ps
`default_nettype none

interface sitda_value_if;
    logic                                valid;
    logic                                ready;
    logic signed [sitda_pkg::VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface sitda_char_if;
    logic                          valid;
    logic                          ready;
    logic [sitda_pkg::CHAR_W-1:0]  char_code;
    logic                          last;

    modport source (output valid, output char_code, output last, input ready);
    modport sink   (input valid, input char_code, input last, output ready);
endinterface

`default_nettype wire

[rtl/core/sitda_dabble.sv]
// Shift-add-3 binary to BCD: one step per cycle on shift, digit read-out by index.
// Depends on sitda_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sitda_dabble (
    input  wire logic                             clk,
    input  wire sitda_pkg::dab_ctrl_t             ctrl,
    input  wire logic [sitda_pkg::VALUE_W-1:0]    load_value,
    input  wire logic [sitda_pkg::DIGIT_IDX_W-1:0] digit_idx,
    output logic      [sitda_pkg::DIGIT_W-1:0]    digit
);
    import sitda_pkg::*;

    logic [NUM_DIGITS-1:0][DIGIT_W-1:0] bcd_reg, bcd_next, bcd_adj;
    logic [VALUE_W-1:0]                 bin_reg, bin_next;
    logic [BCD_W-1:0]                   bcd_flat;

    // add 3 to every digit of five or more, then shift the whole word left
    always_comb
    begin
        for (int d = 0; d < NUM_DIGITS; d++)
        begin
            bcd_adj[d] = (bcd_reg[d] >= DIGIT_W'(5)) ? bcd_reg[d] + DIGIT_W'(3) : bcd_reg[d];
        end
        bcd_flat = bcd_adj;
        bcd_next = {bcd_flat[BCD_W-2:0], bin_reg[VALUE_W-1]};
        bin_next = {bin_reg[VALUE_W-2:0], 1'b0};
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            bcd_reg <= '0;
            bin_reg <= load_value;
        end
        else if (ctrl.shift)
        begin
            bcd_reg <= bcd_next;
            bin_reg <= bin_next;
        end
    end

    assign digit = (digit_idx < DIGIT_IDX_W'(NUM_DIGITS)) ? bcd_reg[digit_idx] : '0;

endmodule

`default_nettype wire

[rtl/core/signed_int_to_decimal_ascii.sv]
// Top level of the signed integer to decimal ASCII converter.
// Depends on sitda_pkg, sitda_if (channel interfaces) and sitda_dabble.
//
//   channel   role    payload                 meaning
//   number    sink    value[31:0] signed      integer to print
//   text      source  char_code[7:0], last    one ASCII character, last marks the end
//
// One number passes through an accept step, the 32-step shift-add-3 loop in the BCD unit,
// a minus sign step for a negative value, one skip step per leading zero plus one to
// leave the skip step, and one emit step per digit. The 32-step BCD loop makes up most
// of that sequence.
// number.ready is high only while the sequencer is idle; a pending character in the
// output register does not block the next transaction. Stalls on text hold the sequencer.
// Reset clears the sequencer and the output valid flag; the datapath needs no reset.
`timescale 1ns / 1ps
`default_nettype none

module signed_int_to_decimal_ascii (
    input  wire logic        clk,
    input  wire logic        rst_n,
    sitda_value_if.sink      number,
    sitda_char_if.source     text
);
    import sitda_pkg::*;

    state_t                  state_reg, state_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [DIGIT_IDX_W-1:0]  idx_reg, idx_next;
    logic                    neg_reg, neg_next;

    logic                    out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]       char_reg, char_next;
    logic                    last_reg, last_next;

    logic                    out_free;
    logic                    accept;
    logic [VALUE_W-1:0]      raw;
    logic [VALUE_W-1:0]      mag;
    logic [DIGIT_W-1:0]      digit;
    dab_ctrl_t               dab_ctrl;

    // take a new number only while the sequencer is idle
    assign number.ready = (state_reg == ST_IDLE);

    assign accept   = number.valid && number.ready;
    assign out_free = !out_valid_reg || text.ready;

    // magnitude in unsigned arithmetic, so the most negative value stays whole
    assign raw = number.value;
    assign mag = raw[VALUE_W-1] ? (~raw + VALUE_W'(1)) : raw;

    sitda_dabble u_dabble (
        .clk        (clk),
        .ctrl       (dab_ctrl),
        .load_value (mag),
        .digit_idx  (idx_reg),
        .digit      (digit)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        count_reg <= count_next;
        idx_reg   <= idx_next;
        neg_reg   <= neg_next;
        char_reg  <= char_next;
        last_reg  <= last_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        neg_next       = neg_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg;
        dab_ctrl       = '0;

        // drop the character once the sink has taken it
        if (out_valid_reg && text.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    dab_ctrl.load = 1'b1;
                    neg_next      = raw[VALUE_W-1];
                    count_next    = '0;
                    state_next    = ST_CONVERT;
                end
            end
            ST_CONVERT:
            begin
                dab_ctrl.shift = 1'b1;
                count_next     = count_reg + CNT_W'(1);
                if (count_reg == CNT_W'(VALUE_W - 1))
                begin
                    idx_next   = DIGIT_IDX_W'(NUM_DIGITS - 1);
                    state_next = neg_reg ? ST_SIGN : ST_SKIP;
                end
            end
            ST_SIGN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = CODE_MINUS;
                    last_next      = 1'b0;
                    state_next     = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                // step past leading zeros; the units digit always prints
                if (digit == '0 && idx_reg != '0)
                begin
                    idx_next = idx_reg - DIGIT_IDX_W'(1);
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = CODE_ZERO + CHAR_W'(digit);
                    last_next      = (idx_reg == '0);
                    if (idx_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg - DIGIT_IDX_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign text.valid     = out_valid_reg;
    assign text.char_code = char_reg;
    assign text.last      = last_reg;

`ifndef SYNTHESIS
    // a new number always starts a fresh conversion from the first shift
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_CONVERT) && (count_reg == '0))
        else $error("accepted transaction did not start conversion");

    // the units digit closes the run with last set
    a_units_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) && out_free && (idx_reg == '0)
        |=> text.valid && text.last && (state_reg == ST_IDLE))
        else $error("final digit not flagged last");

    // a minus sign never ends a run
    a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        text.valid && (text.char_code == CODE_MINUS) |-> !text.last)
        else $error("minus sign flagged last");

    // sign only follows conversion of a negative value
    a_sign_neg: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SIGN) |-> neg_reg)
        else $error("sign state entered for non-negative value");
`endif

endmodule

`default_nettype wire
